>>> rtl/core/rational_arith_reduce_defines.svh
// assertion macros shared by the rtl
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define RAR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define RAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rar_pkg.sv
`timescale 1ns / 1ps
package rar_pkg;

	// operand and result widths
	localparam int OPERAND_W = 16;
	localparam int PROD_W    = 2 * OPERAND_W;
	localparam int NUM_W     = 2 * OPERAND_W + 1;
	localparam int DEN_W     = 2 * OPERAND_W - 1;
	localparam int MAG_W     = 2 * OPERAND_W;
	localparam int K_W       = $clog2(DEN_W);
	localparam int CNT_W     = $clog2(MAG_W);
	localparam int IN_TDATA_W  = ((4 * OPERAND_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;
	localparam int OP_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul2;
		logic sum;
		logic mag;
		logic abs_load;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic out_load;
	} rar_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic den_zero;
		logic gcd_done;
	} rar_stat_t;

endpackage

>>> rtl/core/rational_arith_reduce.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                    | tuser
// s_axis  | in  | a_numerator, a_denominator,           | opcode
//         |     | b_numerator, b_denominator            |
// m_axis  | out | result_numerator, result_denominator  | undefined
//
// one beat at a time: accept, products, combine and magnitudes, then a
// binary gcd (one subtract or halving per cycle), a division setup,
// restoring division of both magnitudes by the gcd, and an unload.
// a zero raw denominator skips gcd and division.
// arst_n clears the sequencer and output valid; no memory to clear.
// the next input beat is taken while a result still waits on m_tready.
module rational_arith_reduce
	import rar_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// a_numerator, a_denominator, b_numerator, b_denominator
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic [OP_W-1:0]        s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// result_numerator, result_denominator
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// undefined
	output logic                   m_tuser
);

`include "rational_arith_reduce_defines.svh"

	rar_cmd_t                cmd;
	rar_stat_t               stat;
	logic signed [NUM_W-1:0] res_num;
	logic [DEN_W-1:0]        res_den;
	logic                    res_undef;

	// sequencer
	rar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// arithmetic
	rar_datapath u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.stat      (stat),
		.in_opcode (s_tuser),
		.in_an     (s_tdata[OPERAND_W-1:0]),
		.in_ad     (s_tdata[2*OPERAND_W-1:OPERAND_W]),
		.in_bn     (s_tdata[3*OPERAND_W-1:2*OPERAND_W]),
		.in_bd     (s_tdata[4*OPERAND_W-1:3*OPERAND_W]),
		.res_num   (res_num),
		.res_den   (res_den),
		.res_undef (res_undef)
	);

	// output beat packing
	assign m_tdata = OUT_TDATA_W'({res_den, res_num});
	assign m_tuser = res_undef;

	// checks
	`RAR_ASSERT_NOW(a_undef_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0,
		"undefined result with nonzero fields")
	`RAR_ASSERT_NOW(a_den_nonzero, clk, arst_n, m_tvalid && !m_tuser,
		res_den != '0, "defined result with zero denominator")
	`RAR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"input taken again right after a beat")

endmodule

>>> rtl/core/rar_datapath.sv
`timescale 1ns / 1ps
module rar_datapath
	import rar_pkg::*;
(
	input  logic                        clk,
	input  rar_cmd_t                    cmd,
	output rar_stat_t                   stat,
	input  logic [OP_W-1:0]             in_opcode,
	input  logic signed [OPERAND_W-1:0] in_an,
	input  logic signed [OPERAND_W-1:0] in_ad,
	input  logic signed [OPERAND_W-1:0] in_bn,
	input  logic signed [OPERAND_W-1:0] in_bd,
	output logic signed [NUM_W-1:0]     res_num,
	output logic [DEN_W-1:0]            res_den,
	output logic                        res_undef
);

	op_t                         op_q;
	logic signed [OPERAND_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [PROD_W-1:0]    pa_q, pb_q, pd_q;
	logic signed [NUM_W-1:0]     n_q;
	logic [MAG_W-1:0]            un_q;
	logic [DEN_W-1:0]            ud_q;
	logic                        neg_q;
	logic [MAG_W-1:0]            x_q, y_q;
	logic [K_W-1:0]              k_q;
	logic [DEN_W-1:0]            g_q;
	logic [DEN_W-1:0]            rem_n_q, rem_d_q;
	logic [MAG_W-1:0]            qn_q, qd_q;
	logic signed [NUM_W-1:0]     res_num_q;
	logic [DEN_W-1:0]            res_den_q;
	logic                        res_undef_q;

	logic signed [PROD_W-1:0] an_x, ad_x, bn_x, bd_x, mul_a_rhs, mul_d_rhs;
	logic signed [NUM_W-1:0]  pa_x, pb_x, neg_n;
	logic signed [PROD_W-1:0] neg_d;
	logic [MAG_W-1:0]         g_base, g_shift, diff_xy, diff_yx;
	logic [MAG_W-1:0]         sh_n, sh_d, g_ext;
	logic [NUM_W-1:0]         qn_ext, qn_neg;

	// sign extension to product width
	assign an_x = PROD_W'(an_q);
	assign ad_x = PROD_W'(ad_q);
	assign bn_x = PROD_W'(bn_q);
	assign bd_x = PROD_W'(bd_q);
	assign mul_a_rhs = (op_q == OP_MUL) ? bn_x : bd_x;
	assign mul_d_rhs = (op_q == OP_DIV) ? bn_x : bd_x;
	assign pa_x = NUM_W'(pa_q);
	assign pb_x = NUM_W'(pb_q);
	assign neg_n = -n_q;
	assign neg_d = -pd_q;

	// gcd status and final shift by the common power of two
	assign stat.den_zero = (pd_q == '0);
	assign stat.gcd_done = (x_q == '0) || (y_q == '0);
	assign g_base  = (x_q == '0) ? y_q : x_q;
	assign g_shift = g_base << k_q;
	assign diff_xy = x_q - y_q;
	assign diff_yx = y_q - x_q;

	// restoring division of both magnitudes by the gcd
	assign g_ext = MAG_W'(g_q);
	assign sh_n  = {rem_n_q, qn_q[MAG_W-1]};
	assign sh_d  = {rem_d_q, qd_q[MAG_W-1]};

	// result sign
	assign qn_ext = NUM_W'(qn_q);
	assign qn_neg = -qn_ext;

	// operand capture and products
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(in_opcode);
			an_q <= in_an;
			ad_q <= in_ad;
			bn_q <= in_bn;
			bd_q <= in_bd;
		end
		// first products go in the cycle after capture
		if (cmd.mul2) begin
			pa_q <= an_x * mul_a_rhs;
			pd_q <= ad_x * mul_d_rhs;
		end
		if (cmd.sum) begin
			pb_q <= bn_x * ad_x;
		end
	end

	// combine, magnitudes and gcd
	always_ff @(posedge clk) begin
		if (cmd.mag) begin
			case (op_q)
				OP_ADD:  n_q <= pa_x + pb_x;
				OP_SUB:  n_q <= pa_x - pb_x;
				default: n_q <= pa_x;
			endcase
		end
		// magnitudes and sign of the combined fraction seed the gcd
		if (cmd.abs_load) begin
			un_q  <= n_q[NUM_W-1] ? neg_n[MAG_W-1:0] : n_q[MAG_W-1:0];
			ud_q  <= pd_q[PROD_W-1] ? neg_d[DEN_W-1:0] : pd_q[DEN_W-1:0];
			neg_q <= n_q[NUM_W-1] ^ pd_q[PROD_W-1];
			x_q   <= n_q[NUM_W-1] ? neg_n[MAG_W-1:0] : n_q[MAG_W-1:0];
			y_q   <= MAG_W'(pd_q[PROD_W-1] ? neg_d[DEN_W-1:0] : pd_q[DEN_W-1:0]);
			k_q   <= '0;
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + K_W'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= diff_xy >> 1;
			end else begin
				y_q <= diff_yx >> 1;
			end
		end
		if (cmd.div_init) begin
			g_q     <= g_shift[DEN_W-1:0];
			rem_n_q <= '0;
			rem_d_q <= '0;
			qn_q    <= un_q;
			qd_q    <= MAG_W'(ud_q);
		end
		if (cmd.div_step) begin
			if (sh_n >= g_ext) begin
				rem_n_q <= DEN_W'(sh_n - g_ext);
				qn_q    <= {qn_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_n_q <= sh_n[DEN_W-1:0];
				qn_q    <= {qn_q[MAG_W-2:0], 1'b0};
			end
			if (sh_d >= g_ext) begin
				rem_d_q <= DEN_W'(sh_d - g_ext);
				qd_q    <= {qd_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_d_q <= sh_d[DEN_W-1:0];
				qd_q    <= {qd_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	// output register: reduced quotients with the result sign, or zero and undefined for a zero denominator
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (stat.den_zero) begin
				res_num_q   <= '0;
				res_den_q   <= '0;
				res_undef_q <= 1'b1;
			end else begin
				res_num_q   <= (neg_q && qn_q != '0) ? qn_neg : qn_ext;
				res_den_q   <= qd_q[DEN_W-1:0];
				res_undef_q <= 1'b0;
			end
		end
	end

	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign res_undef = res_undef_q;

endmodule

>>> rtl/core/rar_ctrl.sv
`timescale 1ns / 1ps
module rar_ctrl
	import rar_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output rar_cmd_t  cmd,
	input  rar_stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MUL2,
		ST_SUM,
		ST_MAG,
		ST_GCD,
		ST_DINIT,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// command decode from state
	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && (state_q == ST_IDLE);
		cmd.mul2     = (state_q == ST_MUL);
		cmd.sum      = (state_q == ST_MUL2);
		cmd.mag      = (state_q == ST_SUM);
		cmd.abs_load = (state_q == ST_MAG);
		cmd.gcd_step = (state_q == ST_GCD) && !stat.gcd_done;
		cmd.div_init = (state_q == ST_DINIT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	// sequencer, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_MAG;
				ST_MAG: begin
					state_q <= stat.den_zero ? ST_DONE : ST_GCD;
				end
				ST_GCD: begin
					if (stat.gcd_done) begin
						state_q <= ST_DINIT;
					end
				end
				ST_DINIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
